/* rtl/jtl_pkg.sv */
// Shared types and character constants for the JSON token lexer.
// No dependencies; imported by every module of the block.
package jtl_pkg;

  // Result kinds on the output stream
  typedef enum logic [2:0] {
    KIND_PUNCT    = 3'd0,
    KIND_STR_BYTE = 3'd1,
    KIND_STR_END  = 3'd2,
    KIND_BOOL     = 3'd3,
    KIND_NUM_BYTE = 3'd4,
    KIND_NUM_END  = 3'd5,
    KIND_ERROR    = 3'd6
  } kind_t;

  // Error codes carried with KIND_ERROR
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EOF_STRING = 3'd1,
    ERR_EOF_BOOL   = 3'd2,
    ERR_BAD_BOOL   = 3'd3,
    ERR_LONE_SIGN  = 3'd4,
    ERR_BAD_NUMBER = 3'd5,
    ERR_UNKNOWN    = 3'd6
  } err_t;

  // Lexer modes
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_BOOL   = 2'd2,
    MODE_NUMBER = 2'd3
  } mode_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_out;
    logic       bool_value;
    err_t       error_code;
  } result_t;

  // Results of one input character, one or two of them
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } step_t;

  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);

  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  function automatic result_t mk_res(kind_t k, logic [7:0] b, logic v, err_t e);
    result_t r;
    r.kind       = k;
    r.byte_out   = b;
    r.bool_value = v;
    r.error_code = e;
    return r;
  endfunction

endpackage

/* rtl/json_token_lexer_core.sv */
// Top level of the JSON token lexer: front end, step queue and back end.
// Depends on jtl_pkg, jtl_front, jtl_queue and jtl_back.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------
//  s_*     | in        | tdata: char_in; tuser: end_of_input
//  m_*     | out       | tdata: kind, byte_out, bool_value, error_code; tlast: last
//
// One character is taken per cycle while the step queue has room; results
// pass through the step queue and the registered output stage.
// A character that closes a number and itself gives a result (punctuation
// or an unknown character) gives two results, sent one after the other.
// Reset (rst, synchronous) empties the queue and returns the lexer to idle.
// A stalled output fills the four-entry queue, then s_tready drops.
module json_token_lexer_core import jtl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tuser,   // [0] end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] kind, [10:3] byte_out, [11] bool_value,
                                 // [14:12] error_code, [15] zero
  output logic        m_tlast
);

  logic    push, pop, q_nonempty, q_full;
  step_t   rec, head;
  result_t out_res;

  jtl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_char  (s_tdata),
    .in_eof   (s_tuser),
    .q_full   (q_full),
    .in_ready (s_tready),
    .push     (push),
    .rec      (rec)
  );

  jtl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rec_in   (rec),
    .pop      (pop),
    .head     (head),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  jtl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res),
    .out_last   (m_tlast)
  );

  // Pack result fields, lowest first
  assign m_tdata = {1'b0, out_res.error_code, out_res.bool_value,
                    out_res.byte_out, out_res.kind};

endmodule

/* rtl/jtl_front.sv */
// JSON token lexer front end (uses jtl_pkg): holds lexer state, produces
// the step record and classifies one character per cycle unless q_full.
module jtl_front import jtl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_char,
  input  logic       in_eof,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output step_t      rec
);

  typedef struct packed {
    logic    emit;
    result_t res;
    mode_t   mode;
    logic    start_bool;
    logic    start_num;
    logic    fail;
  } idle_cls_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_numeric(logic [7:0] c);
    return is_digit(c) || is_sign(c) || (c == CH_DOT) || (c == CH_E_LO) || (c == CH_E_UP);
  endfunction

  // Expected letter of the boolean word at a given position
  function automatic logic [7:0] bool_letter(logic is_true, logic [2:0] pos);
    logic [7:0] ch;
    ch = CH_E_LO;
    if (is_true) begin
      case (pos)
        3'd0:    ch = CH_T;
        3'd1:    ch = CH_R;
        3'd2:    ch = CH_U;
        default: ch = CH_E_LO;
      endcase
    end else begin
      case (pos)
        3'd0:    ch = CH_F;
        3'd1:    ch = CH_A;
        3'd2:    ch = CH_L;
        3'd3:    ch = CH_S;
        default: ch = CH_E_LO;
      endcase
    end
    return ch;
  endfunction

  // Classify a character seen between tokens
  function automatic idle_cls_t classify_idle(logic [7:0] c);
    idle_cls_t r;
    r = '0;
    r.mode = MODE_IDLE;
    if ((c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR))) begin
      r.emit = 1'b0;
    end else if ((c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK) ||
                 (c == CH_RBRACK) || (c == CH_COLON) || (c == CH_COMMA)) begin
      r.emit = 1'b1;
      r.res  = mk_res(KIND_PUNCT, c, 1'b0, ERR_NONE);
    end else if (c == CH_QUOTE) begin
      r.mode = MODE_STRING;
    end else if ((c == CH_T) || (c == CH_F)) begin
      r.mode       = MODE_BOOL;
      r.start_bool = 1'b1;
    end else if (is_sign(c) || is_digit(c)) begin
      r.mode      = MODE_NUMBER;
      r.start_num = 1'b1;
      r.emit      = 1'b1;
      r.res       = mk_res(KIND_NUM_BYTE, c, 1'b0, ERR_NONE);
    end else begin
      r.fail = 1'b1;
      r.emit = 1'b1;
      r.res  = mk_res(KIND_ERROR, c, 1'b0, ERR_UNKNOWN);
    end
    return r;
  endfunction

  mode_t      mode, mode_next;
  logic [2:0] bool_pos, bool_pos_next;
  logic       bool_true, bool_true_next;
  logic       seen_dec, seen_dec_next;
  logic       seen_exp, seen_exp_next;
  logic [7:0] prev_char, prev_char_next;
  logic       err_latched, err_latched_next;

  logic       take;
  logic [1:0] n_res;
  result_t    r0, r1;
  idle_cls_t  idc;
  err_t       follow_err;
  logic       num_bad;
  logic [2:0] pos_inc;
  logic       clear;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign idc      = classify_idle(in_char);
  assign pos_inc  = bool_pos + 3'd1;

  // Check that a pending number may be followed by this character
  always_comb begin
    follow_err = ERR_NONE;
    if (is_sign(prev_char) && !seen_exp && (in_eof || !is_digit(in_char)))
      follow_err = ERR_LONE_SIGN;
    else if (((prev_char == CH_DOT) || (prev_char == CH_E_LO) || (prev_char == CH_E_UP)) &&
             (in_eof || !is_numeric(in_char)))
      follow_err = ERR_BAD_NUMBER;
    else if (is_sign(prev_char) && seen_exp && (in_eof || !is_digit(in_char)))
      follow_err = ERR_BAD_NUMBER;
  end

  // Sign, decimal and exponent rules for a numeric character
  always_comb begin
    num_bad = 1'b0;
    if (is_sign(in_char) && (prev_char != CH_E_LO) && (prev_char != CH_E_UP))
      num_bad = 1'b1;
    if ((in_char == CH_DOT) && (seen_dec || seen_exp))
      num_bad = 1'b1;
    if (((in_char == CH_E_LO) || (in_char == CH_E_UP)) && seen_exp)
      num_bad = 1'b1;
  end

  // Next state and results of one step
  always_comb begin
    mode_next        = mode;
    bool_pos_next    = bool_pos;
    bool_true_next   = bool_true;
    seen_dec_next    = seen_dec;
    seen_exp_next    = seen_exp;
    prev_char_next   = prev_char;
    err_latched_next = err_latched;
    n_res            = 2'd0;
    r0               = '0;
    r1               = '0;
    clear            = 1'b0;

    if (!err_latched) begin
      case (mode)
        MODE_STRING: begin
          n_res = 2'd1;
          if (in_eof) begin
            r0 = mk_res(KIND_ERROR, 8'h00, 1'b0, ERR_EOF_STRING);
            clear = 1'b1;
            err_latched_next = 1'b1;
          end else if (in_char == CH_QUOTE) begin
            r0 = mk_res(KIND_STR_END, 8'h00, 1'b0, ERR_NONE);
            clear = 1'b1;
          end else begin
            r0 = mk_res(KIND_STR_BYTE, in_char, 1'b0, ERR_NONE);
          end
        end
        MODE_BOOL: begin
          if (in_eof) begin
            n_res = 2'd1;
            r0 = mk_res(KIND_ERROR, 8'h00, 1'b0, ERR_EOF_BOOL);
            clear = 1'b1;
            err_latched_next = 1'b1;
          end else if ((bool_pos >= (bool_true ? 3'd4 : 3'd5)) ||
                       (in_char != bool_letter(bool_true, bool_pos))) begin
            n_res = 2'd1;
            r0 = mk_res(KIND_ERROR, in_char, 1'b0, ERR_BAD_BOOL);
            clear = 1'b1;
            err_latched_next = 1'b1;
          end else if (pos_inc == (bool_true ? 3'd4 : 3'd5)) begin
            n_res = 2'd1;
            r0 = mk_res(KIND_BOOL, 8'h00, bool_true, ERR_NONE);
            clear = 1'b1;
          end else begin
            bool_pos_next = pos_inc;
          end
        end
        MODE_NUMBER: begin
          if (follow_err != ERR_NONE) begin
            n_res = 2'd1;
            r0 = mk_res(KIND_ERROR, in_eof ? 8'h00 : in_char, 1'b0, follow_err);
            clear = 1'b1;
            err_latched_next = 1'b1;
          end else if (!in_eof && is_numeric(in_char)) begin
            n_res = 2'd1;
            if (num_bad) begin
              r0 = mk_res(KIND_ERROR, in_char, 1'b0, ERR_BAD_NUMBER);
              clear = 1'b1;
              err_latched_next = 1'b1;
            end else begin
              r0 = mk_res(KIND_NUM_BYTE, in_char, 1'b0, ERR_NONE);
              prev_char_next = in_char;
              if (in_char == CH_DOT)
                seen_dec_next = 1'b1;
              if ((in_char == CH_E_LO) || (in_char == CH_E_UP))
                seen_exp_next = 1'b1;
            end
          end else begin
            // Close the number, then classify the character between tokens
            n_res = 2'd1;
            r0 = mk_res(KIND_NUM_END, 8'h00, 1'b0, ERR_NONE);
            clear = 1'b1;
            if (!in_eof && idc.emit) begin
              n_res = 2'd2;
              r1 = idc.res;
            end
          end
        end
        default: begin
          if (!in_eof && idc.emit) begin
            n_res = 2'd1;
            r0 = idc.res;
          end
        end
      endcase

      // Drop token state once the token is closed or failed
      if (clear) begin
        mode_next      = MODE_IDLE;
        bool_pos_next  = 3'd0;
        bool_true_next = 1'b0;
        seen_dec_next  = 1'b0;
        seen_exp_next  = 1'b0;
        prev_char_next = 8'h00;
      end

      // Apply the between-tokens classification
      if (!in_eof && ((mode == MODE_IDLE) ||
          ((mode == MODE_NUMBER) && (follow_err == ERR_NONE) && !is_numeric(in_char)))) begin
        mode_next = idc.mode;
        if (idc.start_bool) begin
          bool_pos_next  = 3'd1;
          bool_true_next = (in_char == CH_T);
        end
        if (idc.start_num) begin
          seen_dec_next  = 1'b0;
          seen_exp_next  = 1'b0;
          prev_char_next = in_char;
        end
        if (idc.fail)
          err_latched_next = 1'b1;
      end
    end
  end

  assign push     = take && (n_res != 2'd0);
  assign rec.two  = (n_res == 2'd2);
  assign rec.res0 = r0;
  assign rec.res1 = r1;

  // Lexer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      bool_pos    <= 3'd0;
      bool_true   <= 1'b0;
      seen_dec    <= 1'b0;
      seen_exp    <= 1'b0;
      prev_char   <= 8'h00;
      err_latched <= 1'b0;
    end else if (take) begin
      mode        <= mode_next;
      bool_pos    <= bool_pos_next;
      bool_true   <= bool_true_next;
      seen_dec    <= seen_dec_next;
      seen_exp    <= seen_exp_next;
      prev_char   <= prev_char_next;
      err_latched <= err_latched_next;
    end
  end

endmodule

/* rtl/jtl_queue.sv */
// Short queue of step records between lexer front and output back end.
// Uses jtl_pkg for the record type and depth.
module jtl_queue import jtl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t rec_in,
  input  logic  pop,
  output step_t head,
  output logic  nonempty,
  output logic  full
);

  step_t             slots [QDepth];
  logic [QAddrW-1:0] wr_ptr;
  logic [QAddrW-1:0] rd_ptr;
  logic [QAddrW:0]   count;

  assign head     = slots[rd_ptr];
  assign nonempty = (count != '0);
  assign full     = (count == (QAddrW+1)'(QDepth));

  // Store incoming records
  always_ff @(posedge clk) begin
    if (push)
      slots[wr_ptr] <= rec_in;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)
        count <= count + 1'b1;
      else if (pop && !push)
        count <= count - 1'b1;
    end
  end

endmodule

/* rtl/jtl_back.sv */
// Back end of the JSON token lexer: walks the results of each step record
// into a registered output stage. Uses jtl_pkg.
module jtl_back import jtl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_nonempty,
  input  step_t   head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res,
  output logic    out_last
);

  logic    sel;
  logic    load;
  logic    is_last;
  result_t cur;

  assign load    = q_nonempty && (!out_valid || out_ready);
  assign cur     = sel ? head.res1 : head.res0;
  assign is_last = !head.two || sel;
  assign pop     = load && is_last;

  // Output register and result index within the record
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      sel       <= !is_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= cur;
      out_last <= is_last;
    end
  end

endmodule

/* rtl/jtl_checker.sv */
// Port-level checks for json_token_lexer_core, attached with bind.
// Uses jtl_pkg for kind and error codes.
module jtl_checker import jtl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // Hold a stalled output transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  // Error code present exactly on error results
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[2:0] == KIND_ERROR) == (m_tdata[14:12] != ERR_NONE)))
    else $error("error code does not match kind");

  // Boolean value only on boolean results
  a_bool: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> (m_tdata[2:0] == KIND_BOOL))
    else $error("bool_value set outside a boolean result");

  // Nothing follows an error until reset
  a_err_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tdata[2:0] == KIND_ERROR) |-> m_tlast ##1 !m_tvalid)
    else $error("result after error");

endmodule

bind json_token_lexer_core jtl_checker u_jtl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* bench/json_token_lexer_core_tb.sv */
// Self-checking bench for json_token_lexer_core: token streams in, lexed results checked.
// Depends on jtl_pkg and the json_token_lexer_core RTL; needs no other file.
`timescale 1ns / 100ps

module json_token_lexer_core_tb import jtl_pkg::*;;

  localparam int CycleLimit = 400000;
  localparam int QuietCycles = 16;

  typedef struct {
    logic [7:0] ch;
    logic       eof;
    logic       hold;
  } char_beat_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] ch;
    logic       val;
    err_t       code;
    logic       last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  char_beat_t  char_feed[$];
  char_beat_t  beat;
  token_t      expected_tokens[$];
  token_t      step_out[$];
  int          mismatches = 0;
  int          n_items = 1;
  int          n_taken = 0;
  int          cycles = 0;
  logic        hold_next = 1'b0;
  logic        after_number = 1'b0;

  // Lexer state mirrored by the predictor
  mode_t       lex_mode = MODE_IDLE;
  logic [2:0]  word_pos = '0;
  logic        bool_true = 1'b0;
  logic        got_point = 1'b0;
  logic        got_exp = 1'b0;
  logic [7:0]  prev_ch = '0;
  logic        halted = 1'b0;

  json_token_lexer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Character classes
  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_sign(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic bit is_num_char(logic [7:0] c);
    return is_digit(c) || is_sign(c) || c == CH_DOT || c == CH_E_LO || c == CH_E_UP;
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_COLON || c == CH_COMMA;
  endfunction

  // Letter expected at a given position of a boolean literal
  function automatic logic [7:0] bool_letter(logic is_true, logic [2:0] pos);
    if (is_true) begin
      case (pos)
        3'd1: return CH_R;
        3'd2: return CH_U;
        default: return CH_E_LO;
      endcase
    end
    case (pos)
      3'd1: return CH_A;
      3'd2: return CH_L;
      3'd3: return CH_S;
      default: return CH_E_LO;
    endcase
  endfunction

  task automatic add_result(kind_t k, logic [7:0] b, logic v, err_t e);
    token_t t;
    t.kind = k;
    t.ch   = b;
    t.val  = v;
    t.code = e;
    t.last = 1'b0;
    step_out.push_back(t);
  endtask

  task automatic clear_token();
    lex_mode  = MODE_IDLE;
    word_pos  = '0;
    bool_true = 1'b0;
    got_point = 1'b0;
    got_exp   = 1'b0;
    prev_ch   = '0;
  endtask

  task automatic raise_error(logic [7:0] b, err_t e);
    clear_token();
    halted = 1'b1;
    add_result(KIND_ERROR, b, 1'b0, e);
  endtask

  // Classify a character seen between tokens
  task automatic classify_idle(logic [7:0] c);
    if (is_blank(c)) begin
    end else if (is_punct(c)) begin
      add_result(KIND_PUNCT, c, 1'b0, ERR_NONE);
    end else if (c == CH_QUOTE) begin
      lex_mode = MODE_STRING;
    end else if (c == CH_T || c == CH_F) begin
      lex_mode  = MODE_BOOL;
      bool_true = (c == CH_T);
      word_pos  = 3'd1;
    end else if (is_sign(c) || is_digit(c)) begin
      lex_mode  = MODE_NUMBER;
      got_point = 1'b0;
      got_exp   = 1'b0;
      prev_ch   = c;
      add_result(KIND_NUM_BYTE, c, 1'b0, ERR_NONE);
    end else begin
      raise_error(c, ERR_UNKNOWN);
    end
  endtask

  // Check that the open number may be followed by this character or end of input
  function automatic err_t number_follow(logic [7:0] c, logic eof);
    if (is_sign(prev_ch) && !got_exp && (eof || !is_digit(c)))
      return ERR_LONE_SIGN;
    if ((prev_ch == CH_DOT || prev_ch == CH_E_LO || prev_ch == CH_E_UP) &&
        (eof || !is_num_char(c)))
      return ERR_BAD_NUMBER;
    if (is_sign(prev_ch) && got_exp && (eof || !is_digit(c)))
      return ERR_BAD_NUMBER;
    return ERR_NONE;
  endfunction

  // Predict the results of one accepted transaction and queue them
  task automatic lex_char(logic [7:0] c, logic eof);
    err_t       fault;
    logic       bad;
    logic       v;
    logic [7:0] want;
    step_out.delete();
    if (!halted) begin
      case (lex_mode)
        MODE_STRING: begin
          if (eof) begin
            raise_error(8'h00, ERR_EOF_STRING);
          end else if (c == CH_QUOTE) begin
            clear_token();
            add_result(KIND_STR_END, 8'h00, 1'b0, ERR_NONE);
          end else begin
            add_result(KIND_STR_BYTE, c, 1'b0, ERR_NONE);
          end
        end
        MODE_BOOL: begin
          want = bool_letter(bool_true, word_pos);
          if (eof) begin
            raise_error(8'h00, ERR_EOF_BOOL);
          end else if (c != want) begin
            raise_error(c, ERR_BAD_BOOL);
          end else if (int'(word_pos) + 1 == (bool_true ? 4 : 5)) begin
            v = bool_true;
            clear_token();
            add_result(KIND_BOOL, 8'h00, v, ERR_NONE);
          end else begin
            word_pos = word_pos + 3'd1;
          end
        end
        MODE_NUMBER: begin
          fault = number_follow(c, eof);
          if (fault != ERR_NONE) begin
            raise_error(eof ? 8'h00 : c, fault);
          end else if (!eof && is_num_char(c)) begin
            bad = is_sign(c) && prev_ch != CH_E_LO && prev_ch != CH_E_UP;
            if (c == CH_DOT) begin
              bad = bad || got_point || got_exp;
              got_point = 1'b1;
            end
            if (c == CH_E_LO || c == CH_E_UP) begin
              bad = bad || got_exp;
              got_exp = 1'b1;
            end
            if (bad) begin
              raise_error(c, ERR_BAD_NUMBER);
            end else begin
              prev_ch = c;
              add_result(KIND_NUM_BYTE, c, 1'b0, ERR_NONE);
            end
          end else begin
            // Close the number, then treat the character as between tokens
            clear_token();
            add_result(KIND_NUM_END, 8'h00, 1'b0, ERR_NONE);
            if (!eof) classify_idle(c);
          end
        end
        default: begin
          lex_mode = MODE_IDLE;
          if (!eof) classify_idle(c);
        end
      endcase
      if (step_out.size() != 0) begin
        step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
      end
    end
  endtask

  // Stimulus building
  task automatic push_beat(logic [7:0] c, logic eof);
    char_beat_t b;
    b.ch   = c;
    b.eof  = eof;
    b.hold = hold_next;
    hold_next = 1'b0;
    char_feed.push_back(b);
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_beat(s[i], 1'b0);
  endtask

  task automatic push_digits(int lo, int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) push_beat(CH_ZERO + 8'($urandom_range(9)), 1'b0);
  endtask

  function automatic logic [7:0] any_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] any_punct();
    case ($urandom_range(5))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LBRACK;
      3: return CH_RBRACK;
      4: return CH_COLON;
      default: return CH_COMMA;
    endcase
  endfunction

  // Well-formed number: sign? digits (. digits*)? ([eE] sign? digits)?
  task automatic push_number();
    int   frac;
    logic want_exp;
    if ($urandom_range(3) == 0) push_beat($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0);
    push_digits(1, 3);
    want_exp = ($urandom_range(2) == 0);
    if ($urandom_range(1)) begin
      push_beat(CH_DOT, 1'b0);
      frac = $urandom_range(4) == 0 ? 0 : $urandom_range(3, 1);
      repeat (frac) push_beat(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      // A bare point must be followed by an exponent
      if (frac == 0) want_exp = 1'b1;
    end
    if (want_exp) begin
      push_beat($urandom_range(1) ? CH_E_LO : CH_E_UP, 1'b0);
      if ($urandom_range(1)) push_beat($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0);
      push_digits(1, 2);
    end
  endtask

  task automatic push_token();
    int         sel;
    int         n;
    logic [7:0] c;
    sel = $urandom_range(99);
    if (sel < 15) begin
      repeat ($urandom_range(3, 1)) push_beat(any_blank(), 1'b0);
      after_number = 1'b0;
    end else if (sel < 35) begin
      push_beat(any_punct(), 1'b0);
      after_number = 1'b0;
    end else if (sel < 55) begin
      push_beat(CH_QUOTE, 1'b0);
      n = $urandom_range(6);
      repeat (n) begin
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
        push_beat(c, 1'b0);
      end
      push_beat(CH_QUOTE, 1'b0);
      after_number = 1'b0;
    end else if (sel < 70) begin
      if ($urandom_range(1)) push_text("true");
      else push_text("false");
      after_number = 1'b0;
    end else if (sel < 95) begin
      // Keep two numbers apart so they do not merge into one
      if (after_number) push_beat($urandom_range(1) ? any_blank() : any_punct(), 1'b0);
      push_number();
      after_number = 1'b1;
    end else begin
      push_beat(8'($urandom_range(255)), 1'b1);
      after_number = 1'b0;
    end
  endtask

  // One error to finish the stream; it latches until reset
  task automatic push_fault();
    logic [7:0] c;
    push_beat(CH_SPACE, 1'b0);
    case ($urandom_range(5))
      0: begin
        push_text("\"ab");
        push_beat(8'($urandom_range(255)), 1'b1);
      end
      1: begin
        if ($urandom_range(1)) push_text("tr");
        else push_text("fal");
        push_beat(8'($urandom_range(255)), 1'b1);
      end
      2: begin
        if ($urandom_range(1)) push_text("tru");
        else push_text("f");
        push_beat(CH_CR, 1'b0);
      end
      3: begin
        push_beat($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0);
        push_beat($urandom_range(1) ? CH_COMMA : CH_DOT, 1'($urandom_range(1)));
      end
      4: begin
        case ($urandom_range(4))
          0: push_text("1.5.");
          1: push_text("2e,");
          2: push_text("3E+ ");
          3: push_text("4-");
          default: push_text("5e2e");
        endcase
      end
      default: begin
        do c = 8'($urandom_range(255));
        while (is_blank(c) || is_punct(c) || c == CH_QUOTE || c == CH_T || c == CH_F ||
               is_sign(c) || is_digit(c));
        push_beat(c, 1'b0);
      end
    endcase
    // Drop these: the lexer stays silent until reset
    repeat (8) push_beat(8'($urandom_range(255)), 1'(($urandom_range(3) == 0)));
  endtask

  task automatic build_stream();
    // Directed: every punctuation class, extreme bytes, boolean, signed number
    push_text("{\"");
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b0);
    push_text("\":[true,-0.5e+3]}9");
    push_beat(8'h00, 1'b1);
    push_text("\t");
    hold_next = 1'b1;
    while (char_feed.size() < 1600) begin
      if ($urandom_range(99) == 0) hold_next = 1'b1;
      push_token();
    end
    push_fault();
  endtask

  function automatic int send_idle_pct();
    case (n_taken * 3 / n_items)
      0: return 17;
      1: return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (n_taken * 3 / n_items)
      0: return 67;
      1: return 17;
      default: return 0;
    endcase
  endfunction

  task automatic check_token(logic [15:0] d, logic l);
    token_t e;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result data=%04h last=%0b", $time, d, l);
    end else begin
      e = expected_tokens.pop_front();
      if (d[2:0] !== e.kind || d[10:3] !== e.ch || d[11] !== e.val ||
          d[14:12] !== e.code || d[15] !== 1'b0 || l !== e.last) begin
        mismatches++;
        $display("%0t: expected kind=%0d byte=%02h bool=%0b err=%0d last=%0b, %s",
                 $time, e.kind, e.ch, e.val, e.code, e.last,
                 $sformatf("got kind=%0d byte=%02h bool=%0b err=%0d pad=%0b last=%0b",
                           d[2:0], d[10:3], d[11], d[14:12], d[15], l));
      end
    end
  endtask

  // Driver: predict on each accepted transaction, then offer the next character
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        lex_char(s_tdata, s_tuser);
        n_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (char_feed.size() != 0 && !(char_feed[0].hold && expected_tokens.size() != 0) &&
            $urandom_range(99) >= send_idle_pct()) begin
          beat = char_feed.pop_front();
          s_tdata  <= beat.ch;
          s_tuser  <= beat.eof;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_token(m_tdata, m_tlast);
      m_tready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("json_token_lexer_core verification failed");
      $finish;
    end
  end

  initial begin
    build_stream();
    n_items = char_feed.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (char_feed.size() == 0 && !s_tvalid);
    wait (expected_tokens.size() == 0);
    repeat (QuietCycles) @(posedge clk);
    if (mismatches == 0)
      $display("json_token_lexer_core verification clean");
    else
      $display("json_token_lexer_core verification failed");
    $finish;
  end

endmodule
